// ===== rtl/tpbc_pkg.sv =====
// Package for the tracked point box clusterer.
// Holds sizes, config and result codes, and the structs shared between the modules.
// No dependencies.
`timescale 1ns / 1ps

package tpbc_pkg;

  localparam int unsigned MaxBoxes  = 3;
  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned CntW      = 11;
  localparam int unsigned BoxIdxW   = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int unsigned OpenW     = $clog2(MaxBoxes + 1);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CntW-1:0] CntCap =
    (MaxPoints > 2047) ? CntW'(2047) : CntW'(MaxPoints);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_JOIN_MARGIN   = 3'd0,
    CFG_WINDOW_TOP    = 3'd1,
    CFG_WINDOW_BOTTOM = 3'd2,
    CFG_MIN_MOTION    = 3'd3,
    CFG_MAX_MOTION    = 3'd4,
    CFG_MIN_POINTS    = 3'd5,
    CFG_MAX_EXTENT    = 3'd6,
    CFG_MIN_EXTENT    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RES_OK       = 2'd0,
    RES_OVERFLOW = 2'd1,
    RES_CHECK    = 2'd2,
    RES_EMPTY    = 2'd3
  } result_code_e;

  typedef struct packed {
    logic [CoordW-1:0] join_margin;
    logic [CoordW-1:0] window_top;
    logic [CoordW-1:0] window_bottom;
    logic [CoordW-1:0] min_motion;
    logic [CoordW-1:0] max_motion;
    logic [CntW-1:0]   min_points;
    logic [CoordW-1:0] max_extent;
    logic [CoordW-1:0] min_extent;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    join_margin:   16'd800,
    window_top:    16'd1920,
    window_bottom: 16'd8400,
    min_motion:    16'd32,
    max_motion:    16'd1600,
    min_points:    11'd6,
    max_extent:    16'd3200,
    min_extent:    16'd320
  };

  // classified point, front to back
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              keep;
    logic              in_win;
    logic              last;
  } pt_t;

  typedef struct packed {
    logic [CoordW-1:0] min_x;
    logic [CoordW-1:0] min_y;
    logic [CoordW-1:0] max_x;
    logic [CoordW-1:0] max_y;
    logic [CntW-1:0]   members;
  } box_t;

  typedef struct packed {
    box_t [MaxBoxes-1:0] boxes;
    logic [OpenW-1:0]    open;
    logic                overflow;
    logic                seeded;
  } frame_t;

  // result word, code in the low bits
  typedef struct packed {
    logic [CntW-1:0]   point_count;
    logic [CoordW-1:0] bottom_y;
    logic [CoordW:0]   center_x;
    result_code_e      result_code;
  } res_t;

endpackage

// ===== rtl/tracked_point_box_clusterer_unit.sv =====
// Top level of the tracked point box clusterer: config registers, front end,
// point queue, box back end and result stage. Depends on tpbc_pkg and all tpbc_* modules.
//
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata 64b, tuser found, tlast last point
// m_axis   | out | m_axis_tvalid/tready   | tdata 48b result word
// cfg      | in  | cfg_we_i               | cfg_idx_i 3b, cfg_data_i 16b
//
// One point word per cycle sustained; the box back end folds one point per cycle.
// A last point passes through the queue, the back end's snapshot register and
// the result register before m_axis_tvalid rises.
// s_axis stalls only when the 4-deep queue is full; a last point waits at the
// queue head while the previous frame's snapshot cannot enter the result stage.
// Reset clears frame state and loads config defaults.
`timescale 1ns / 1ps

module tracked_point_box_clusterer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // ref_x, ref_y, other_x, other_y
  input  logic                          s_axis_tuser,  // found
  input  logic                          s_axis_tlast,  // last_point
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // result_code, center_x, bottom_y,
                                                       // point_count, zero pad
  input  logic                          cfg_we_i,
  input  logic [tpbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpbc_pkg::CfgDataW-1:0] cfg_data_i
);
  import tpbc_pkg::*;

  cfg_t   cfg_q;
  pt_t    pt_in, pt_head;
  logic   fifo_full, fifo_empty, pop, push;
  logic   snap_valid, snap_ready;
  frame_t snap;
  res_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_JOIN_MARGIN:   cfg_q.join_margin   <= cfg_data_i;
        CFG_WINDOW_TOP:    cfg_q.window_top    <= cfg_data_i;
        CFG_WINDOW_BOTTOM: cfg_q.window_bottom <= cfg_data_i;
        CFG_MIN_MOTION:    cfg_q.min_motion    <= cfg_data_i;
        CFG_MAX_MOTION:    cfg_q.max_motion    <= cfg_data_i;
        CFG_MIN_POINTS:    cfg_q.min_points    <= cfg_data_i[CntW-1:0];
        CFG_MAX_EXTENT:    cfg_q.max_extent    <= cfg_data_i;
        CFG_MIN_EXTENT:    cfg_q.min_extent    <= cfg_data_i;
      endcase
    end
  end

  assign s_axis_tready = !fifo_full;
  assign push          = s_axis_tvalid && !fifo_full;

  tpbc_front u_front (
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .s_tlast_i (s_axis_tlast),
    .cfg_i     (cfg_q),
    .pt_o      (pt_in)
  );

  tpbc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (pt_in),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .rdata_o (pt_head)
  );

  tpbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .avail_i      (!fifo_empty),
    .pt_i         (pt_head),
    .pop_o        (pop),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_ready_i (snap_ready)
  );

  tpbc_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_o        (res),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, res};

  a_ok_has_points : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.result_code == RES_OK) |-> (res.point_count >= cfg_q.min_points))
    else $error("ok result below min_points");

  a_no_box_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res.result_code == RES_EMPTY || res.result_code == RES_OVERFLOW))
      |-> (res.center_x == '0 && res.bottom_y == '0 && res.point_count == '0))
    else $error("nonzero payload without a box");

  a_snap_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid && !snap_ready) |=> (snap_valid && $stable(snap)))
    else $error("frame snapshot lost while result stage busy");

endmodule

// ===== rtl/tpbc_front.sv =====
// Front end: classifies each incoming point (found, motion, window).
// Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_front (
  input  logic [63:0]          s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 s_tlast_i,
  input  tpbc_pkg::cfg_t       cfg_i,
  output tpbc_pkg::pt_t        pt_o
);
  import tpbc_pkg::*;

  logic [CoordW-1:0] ref_x, ref_y, other_x, other_y, dx, dy;
  logic [CoordW:0]   motion;

  assign ref_x   = s_tdata_i[15:0];
  assign ref_y   = s_tdata_i[31:16];
  assign other_x = s_tdata_i[47:32];
  assign other_y = s_tdata_i[63:48];

  assign dx     = (ref_x > other_x) ? ref_x - other_x : other_x - ref_x;
  assign dy     = (ref_y > other_y) ? ref_y - other_y : other_y - ref_y;
  assign motion = {1'b0, dx} + {1'b0, dy};

  always_comb begin
    pt_o.x      = ref_x;
    pt_o.y      = ref_y;
    pt_o.keep   = s_tuser_i && (motion > {1'b0, cfg_i.min_motion})
                  && (motion < {1'b0, cfg_i.max_motion});
    pt_o.in_win = !((ref_y < cfg_i.window_top) || (ref_y > cfg_i.window_bottom));
    pt_o.last   = s_tlast_i;
  end

endmodule

// ===== rtl/tpbc_fifo.sv =====
// Short point queue between front and back.
// Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpbc_pkg::pt_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tpbc_pkg::pt_t rdata_o
);
  import tpbc_pkg::*;

  pt_t                 mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + FifoCntW'(1);
      2'b01:   cnt_d = cnt_q - FifoCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + FifoPtrW'(1);
      if (pop_i)  rptr_q <= rptr_q + FifoPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

endmodule

// ===== rtl/tpbc_back.sv =====
// Back end: grows the boxes one point per cycle; on the last point of a frame
// hands a snapshot of the frame to the result stage. Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpbc_pkg::cfg_t   cfg_i,
  input  logic             avail_i,
  input  tpbc_pkg::pt_t    pt_i,
  output logic             pop_o,
  output logic             snap_valid_o,
  output tpbc_pkg::frame_t snap_o,
  input  logic             snap_ready_i
);
  import tpbc_pkg::*;

  frame_t              frame_q, frame_d, frame_nxt;
  frame_t              snap_q, snap_d;
  logic                snap_valid_q, snap_valid_d;
  logic [MaxBoxes-1:0] hit;
  logic [BoxIdxW-1:0]  hit_idx;
  logic [BoxIdxW-1:0]  new_idx;
  logic [CoordW:0]     x_lo, y_lo, x_hi, y_hi;
  box_t                cur;

  assign pop_o = avail_i && (!pt_i.last || !snap_valid_q || snap_ready_i);

  always_comb begin
    hit     = '0;
    hit_idx = '0;
    new_idx = frame_q.open[BoxIdxW-1:0];
    for (int j = 0; j < MaxBoxes; j++) begin
      hit[j] = (OpenW'(j) < frame_q.open)
        && !(({1'b0, pt_i.x} + {1'b0, cfg_i.join_margin}) < {1'b0, frame_q.boxes[j].min_x}
          || {1'b0, pt_i.x} > ({1'b0, frame_q.boxes[j].max_x} + {1'b0, cfg_i.join_margin})
          || ({1'b0, pt_i.y} + {1'b0, cfg_i.join_margin}) < {1'b0, frame_q.boxes[j].min_y}
          || {1'b0, pt_i.y} > ({1'b0, frame_q.boxes[j].max_y} + {1'b0, cfg_i.join_margin}));
    end
    for (int j = MaxBoxes - 1; j >= 0; j--) begin
      if (hit[j]) hit_idx = BoxIdxW'(j);
    end
  end

  assign x_lo = {1'b0, pt_i.x};
  assign y_lo = {1'b0, pt_i.y};
  assign x_hi = x_lo;
  assign y_hi = y_lo;

  always_comb begin
    frame_nxt = frame_q;
    cur       = frame_q.boxes[hit_idx];
    if (pt_i.keep) begin
      if (!frame_q.seeded) begin
        frame_nxt.boxes[0] = '{min_x: pt_i.x, min_y: pt_i.y, max_x: pt_i.x,
                               max_y: pt_i.y, members: CntW'(1)};
        frame_nxt.open     = OpenW'(1);
        frame_nxt.seeded   = 1'b1;
      end else if (pt_i.in_win) begin
        if (|hit) begin
          if (x_lo < {1'b0, cur.min_x}) cur.min_x = pt_i.x;
          if (y_lo < {1'b0, cur.min_y}) cur.min_y = pt_i.y;
          if (x_hi > {1'b0, cur.max_x}) cur.max_x = pt_i.x;
          if (y_hi > {1'b0, cur.max_y}) cur.max_y = pt_i.y;
          if (cur.members < CntCap) cur.members = cur.members + CntW'(1);
          frame_nxt.boxes[hit_idx] = cur;
        end else if (frame_q.open < OpenW'(MaxBoxes)) begin
          frame_nxt.boxes[new_idx] = '{min_x: pt_i.x, min_y: pt_i.y, max_x: pt_i.x,
                                       max_y: pt_i.y, members: CntW'(1)};
          frame_nxt.open = frame_q.open + OpenW'(1);
        end else begin
          frame_nxt.overflow = 1'b1;
        end
      end
    end
  end

  always_comb begin
    frame_d      = frame_q;
    snap_d       = snap_q;
    snap_valid_d = snap_valid_q && !snap_ready_i;
    if (pop_o) begin
      if (pt_i.last) begin
        frame_d      = '0;
        snap_d       = frame_nxt;
        snap_valid_d = 1'b1;
      end else begin
        frame_d = frame_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q      <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      frame_q      <= frame_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// ===== rtl/tpbc_result.sv =====
// Result stage: picks the densest box of a finished frame, checks it and
// holds the result word for the output stream. Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_result (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpbc_pkg::cfg_t   cfg_i,
  input  logic             snap_valid_i,
  input  tpbc_pkg::frame_t snap_i,
  output logic             snap_ready_o,
  output logic             out_valid_o,
  output tpbc_pkg::res_t   out_o,
  input  logic             out_ready_i
);
  import tpbc_pkg::*;

  logic               out_valid_q, out_valid_d;
  res_t               out_q, res;
  logic [BoxIdxW-1:0] best;
  box_t               bb;
  logic [CoordW-1:0]  w, h;
  logic               bad;

  assign snap_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    best = '0;
    for (int j = 1; j < MaxBoxes; j++) begin
      if (snap_i.boxes[j].members > snap_i.boxes[best].members) best = BoxIdxW'(j);
    end
  end

  assign bb  = snap_i.boxes[best];
  assign w   = bb.max_x - bb.min_x;
  assign h   = bb.max_y - bb.min_y;
  assign bad = (bb.members < cfg_i.min_points) || (w > cfg_i.max_extent)
            || (h > cfg_i.max_extent) || (bb.max_y > cfg_i.window_bottom)
            || (bb.max_y < cfg_i.window_top) || (w < cfg_i.min_extent)
            || (h < cfg_i.min_extent);

  always_comb begin
    res = '0;
    priority if (!snap_i.seeded) begin
      res.result_code = RES_EMPTY;
    end else if (snap_i.overflow) begin
      res.result_code = RES_OVERFLOW;
    end else begin
      res.result_code = bad ? RES_CHECK : RES_OK;
      res.center_x    = {1'b0, bb.min_x} + {1'b0, bb.max_x};
      res.bottom_y    = bb.max_y;
      res.point_count = bb.members;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (snap_valid_i && snap_ready_o) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i && snap_ready_o) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== verif/tb.sv =====
// Testbench for tracked_point_box_clusterer_unit: directed frames, register
// sweeps, member saturation and random frames, checked against a box predictor.
// Depends on tpbc_pkg and the clusterer RTL.
`timescale 1ns / 1ps

module tb;
  import tpbc_pkg::*;

  localparam int BOX_SLOTS    = 3;
  localparam int MEMBER_CAP   = 1024;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [15:0] reg_words_t [8];

  localparam reg_words_t DEFAULT_REGS =
    '{16'd800, 16'd1920, 16'd8400, 16'd32, 16'd1600, 16'd6, 16'd3200, 16'd320};

  typedef struct packed {
    logic [15:0] ref_x;
    logic [15:0] ref_y;
    logic [15:0] other_x;
    logic [15:0] other_y;
    logic        found;
    logic        last;
  } point_t;

  typedef struct packed {
    logic [15:0] lo_x;
    logic [15:0] lo_y;
    logic [15:0] hi_x;
    logic [15:0] hi_y;
    logic [10:0] members;
  } cluster_box_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // ref_x, ref_y, other_x, other_y
  logic        s_axis_tuser = 1'b0; // found
  logic        s_axis_tlast = 1'b0; // last_point
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // result_code, center_x, bottom_y, point_count, pad
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  tracked_point_box_clusterer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int           src_idle_pct;
  int           snk_stall_pct;
  int           points_sent;
  int           err_cnt;
  res_t         due_results[$];
  res_t         seen_word;
  res_t         due_word;

  // predictor state
  cfg_t         regs_q;
  cluster_box_t boxes_q[BOX_SLOTS];
  int           open_q;
  bit           overflow_q;
  bit           seeded_q;

  function automatic void clear_frame();
    for (int j = 0; j < BOX_SLOTS; j++) boxes_q[j] = '0;
    open_q     = 0;
    overflow_q = 1'b0;
    seeded_q   = 1'b0;
  endfunction

  function automatic void store_reg(input cfg_idx_e idx, input logic [15:0] d);
    case (idx)
      CFG_JOIN_MARGIN:   regs_q.join_margin   = d;
      CFG_WINDOW_TOP:    regs_q.window_top    = d;
      CFG_WINDOW_BOTTOM: regs_q.window_bottom = d;
      CFG_MIN_MOTION:    regs_q.min_motion    = d;
      CFG_MAX_MOTION:    regs_q.max_motion    = d;
      CFG_MIN_POINTS:    regs_q.min_points    = d[10:0];
      CFG_MAX_EXTENT:    regs_q.max_extent    = d;
      CFG_MIN_EXTENT:    regs_q.min_extent    = d;
      default: ;
    endcase
  endfunction

  function automatic logic [16:0] span(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? {1'b0, a} - {1'b0, b} : {1'b0, b} - {1'b0, a};
  endfunction

  function automatic void seed_box(input int k, input logic [15:0] x, input logic [15:0] y);
    boxes_q[k].lo_x    = x;
    boxes_q[k].hi_x    = x;
    boxes_q[k].lo_y    = y;
    boxes_q[k].hi_y    = y;
    boxes_q[k].members = 11'd1;
  endfunction

  // folds one accepted word into the frame; a last word queues the frame verdict
  function automatic void cluster_point(input point_t p);
    logic [16:0] motion;
    logic [16:0] x, y, jm;
    logic [15:0] w, h;
    int          best;
    bit          placed;
    res_t        r;
    motion = span(p.ref_x, p.other_x) + span(p.ref_y, p.other_y);
    x      = {1'b0, p.ref_x};
    y      = {1'b0, p.ref_y};
    jm     = {1'b0, regs_q.join_margin};
    if (p.found && motion > regs_q.min_motion && motion < regs_q.max_motion) begin
      if (!seeded_q) begin
        seed_box(0, p.ref_x, p.ref_y);
        open_q   = 1;
        seeded_q = 1'b1;
      end else if (p.ref_y >= regs_q.window_top && p.ref_y <= regs_q.window_bottom) begin
        placed = 1'b0;
        for (int j = 0; j < open_q; j++) begin
          if (!placed && x + jm >= boxes_q[j].lo_x && x <= boxes_q[j].hi_x + jm &&
              y + jm >= boxes_q[j].lo_y && y <= boxes_q[j].hi_y + jm) begin
            if (p.ref_x < boxes_q[j].lo_x) boxes_q[j].lo_x = p.ref_x;
            if (p.ref_y < boxes_q[j].lo_y) boxes_q[j].lo_y = p.ref_y;
            if (p.ref_x > boxes_q[j].hi_x) boxes_q[j].hi_x = p.ref_x;
            if (p.ref_y > boxes_q[j].hi_y) boxes_q[j].hi_y = p.ref_y;
            if (boxes_q[j].members < MEMBER_CAP) boxes_q[j].members++;
            placed = 1'b1;
          end
        end
        if (!placed) begin
          if (open_q < BOX_SLOTS) begin
            seed_box(open_q, p.ref_x, p.ref_y);
            open_q++;
          end else begin
            overflow_q = 1'b1;
          end
        end
      end
    end
    if (p.last) begin
      r = '0;
      if (!seeded_q) begin
        r.result_code = RES_EMPTY;
      end else if (overflow_q) begin
        r.result_code = RES_OVERFLOW;
      end else begin
        best = 0;
        for (int j = 1; j < open_q; j++)
          if (boxes_q[j].members > boxes_q[best].members) best = j;
        w = boxes_q[best].hi_x - boxes_q[best].lo_x;
        h = boxes_q[best].hi_y - boxes_q[best].lo_y;
        r.center_x    = {1'b0, boxes_q[best].lo_x} + {1'b0, boxes_q[best].hi_x};
        r.bottom_y    = boxes_q[best].hi_y;
        r.point_count = boxes_q[best].members;
        if (r.point_count < regs_q.min_points || w > regs_q.max_extent ||
            h > regs_q.max_extent || r.bottom_y > regs_q.window_bottom ||
            r.bottom_y < regs_q.window_top || w < regs_q.min_extent ||
            h < regs_q.min_extent)
          r.result_code = RES_CHECK;
        else
          r.result_code = RES_OK;
      end
      due_results = {due_results, r};
      clear_frame();
    end
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word = m_axis_tdata[45:0];
      if (due_results.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        err_cnt++;
      end else begin
        due_word = due_results.pop_front();
        if (seen_word.result_code !== due_word.result_code) begin
          $error("result_code: expected %0d, got %0d", due_word.result_code,
                 seen_word.result_code);
          err_cnt++;
        end
        if (seen_word.center_x !== due_word.center_x) begin
          $error("center_x: expected %0d, got %0d", due_word.center_x, seen_word.center_x);
          err_cnt++;
        end
        if (seen_word.bottom_y !== due_word.bottom_y) begin
          $error("bottom_y: expected %0d, got %0d", due_word.bottom_y, seen_word.bottom_y);
          err_cnt++;
        end
        if (seen_word.point_count !== due_word.point_count) begin
          $error("point_count: expected %0d, got %0d", due_word.point_count,
                 seen_word.point_count);
          err_cnt++;
        end
        if (m_axis_tdata[47:46] !== 2'b00) begin
          $error("pad: expected 0, got %0d", m_axis_tdata[47:46]);
          err_cnt++;
        end
      end
    end
  end

  task automatic push_point(input point_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.other_y, p.other_x, p.ref_y, p.ref_x};
    s_axis_tuser  <= p.found;
    s_axis_tlast  <= p.last;
    do @(posedge clk_i); while (!s_axis_tready);
    cluster_point(p);
    points_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input reg_words_t w);
    cfg_idx_e idx;
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= w[i];
      @(posedge clk_i);
      store_reg(idx, w[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_regs(output reg_words_t w);
    w[CFG_JOIN_MARGIN]   = 16'($urandom_range(2000));
    w[CFG_WINDOW_TOP]    = 16'($urandom_range(4000));
    w[CFG_WINDOW_BOTTOM] = w[CFG_WINDOW_TOP] + 16'($urandom_range(8000));
    w[CFG_MIN_MOTION]    = 16'($urandom_range(100));
    w[CFG_MAX_MOTION]    = w[CFG_MIN_MOTION] + 16'd2 + 16'($urandom_range(3000));
    w[CFG_MIN_POINTS]    = 16'($urandom_range(12, 1));
    w[CFG_MAX_EXTENT]    = 16'($urandom_range(5000, 500));
    w[CFG_MIN_EXTENT]    = 16'($urandom_range(500));
  endtask

  function automatic point_t mk_pt(input int rx, ry, ox, oy, input int found, last);
    point_t p;
    p.ref_x   = 16'(rx);
    p.ref_y   = 16'(ry);
    p.other_x = 16'(ox);
    p.other_y = 16'(oy);
    p.found   = (found != 0);
    p.last    = (last != 0);
    return p;
  endfunction

  function automatic logic [15:0] clip16(input int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // point near a cluster center with motion mostly inside the keep limits
  function automatic point_t make_point(input int cx, cy, spread, input bit last);
    point_t p;
    int     x, y, m, dx, dy, lo, hi;
    if ($urandom_range(9) == 0) begin
      p = mk_pt($urandom, $urandom, $urandom, $urandom, $urandom_range(1), int'(last));
      return p;
    end
    x  = int'(clip16(cx + int'($urandom_range(2 * spread)) - spread));
    y  = int'(clip16(cy + int'($urandom_range(2 * spread)) - spread));
    lo = int'(regs_q.min_motion) + 1;
    hi = int'(regs_q.max_motion) - 1;
    if (lo > hi || $urandom_range(19) == 0) m = $urandom_range(131070);
    else m = $urandom_range(hi, lo);
    dx = (m > 65535) ? $urandom_range(65535, m - 65535) : $urandom_range(m);
    dy = m - dx;
    p = mk_pt(x, y, int'(clip16((x + dx <= 65535) ? x + dx : x - dx)),
              int'(clip16((y + dy <= 65535) ? y + dy : y - dy)),
              int'($urandom_range(19) != 0), int'(last));
    return p;
  endfunction

  task automatic send_frame(input int n);
    int cxs[4];
    int cys[4];
    int ncl, spread, r, k;
    r   = $urandom_range(99);
    ncl = (r < 60) ? 1 : (r < 85) ? 2 : 4;
    spread = $urandom_range(1000);
    for (int j = 0; j < 4; j++) begin
      cxs[j] = $urandom_range(65535);
      if (regs_q.window_top <= regs_q.window_bottom)
        cys[j] = $urandom_range(regs_q.window_bottom, regs_q.window_top);
      else
        cys[j] = $urandom_range(65535);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(ncl - 1);
      push_point(make_point(cxs[k], cys[k], spread, i == n - 1));
    end
  endtask

  task automatic random_frames(input int count);
    int goal;
    goal = points_sent + count;
    while (points_sent < goal)
      send_frame(($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(20, 1));
  endtask

  task automatic set_idle(input int src, input int snk);
    src_idle_pct  = src;
    snk_stall_pct = snk;
  endtask

  task automatic test_empty_frames();
    push_point(mk_pt(0, 0, 0, 0, 0, 1));
    push_point(mk_pt(65535, 65535, 0, 0, 0, 1));
  endtask

  task automatic test_motion_limits();
    push_point(mk_pt(4000, 4000, 4032, 4000, 1, 0));   // equal to min, dropped
    push_point(mk_pt(4000, 4000, 4000, 5600, 1, 0));   // equal to max, dropped
    push_point(mk_pt(4000, 4000, 3967, 4000, 0, 0));   // not found
    push_point(mk_pt(4000, 4000, 3000, 3401, 1, 1));
  endtask

  task automatic test_seed_outside_window();
    push_point(mk_pt(1000, 100, 1040, 100, 1, 0));     // seeds with no window test
    push_point(mk_pt(1000, 9000, 1040, 9000, 1, 0));
    push_point(mk_pt(1100, 1919, 1140, 1919, 1, 1));
  endtask

  task automatic test_good_box();
    push_point(mk_pt(5000, 4000, 5100, 4000, 1, 0));
    push_point(mk_pt(5400, 4000, 5500, 4000, 1, 0));
    push_point(mk_pt(5000, 4400, 5100, 4400, 1, 0));
    push_point(mk_pt(5400, 4400, 5300, 4400, 1, 0));
    push_point(mk_pt(5200, 4200, 5200, 4300, 1, 0));
    push_point(mk_pt(5200, 4200, 5150, 4150, 1, 1));
  endtask

  task automatic test_box_overflow();
    push_point(mk_pt(1000, 3000, 1100, 3000, 1, 0));
    push_point(mk_pt(10000, 3000, 10100, 3000, 1, 0));
    push_point(mk_pt(20000, 3000, 20100, 3000, 1, 0));
    push_point(mk_pt(30000, 3000, 30100, 3000, 1, 1));
  endtask

  // tie between two single boxes, the first-opened box wins
  task automatic test_field_extremes();
    push_point(mk_pt(0, 2000, 0, 2040, 1, 0));
    push_point(mk_pt(65535, 65535, 65435, 65535, 1, 0));
    push_point(mk_pt(65535, 8400, 65485, 8400, 1, 1));
  endtask

  task automatic test_config_sweep();
    reg_words_t w;
    set_idle(19, 19);
    write_regs('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    random_frames(20);
    write_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF});
    random_frames(20);
    write_regs('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0});
    random_frames(20);
    write_regs('{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0});
    random_frames(20);
    repeat (2) begin
      random_regs(w);
      write_regs(w);
      random_frames(20);
    end
  endtask

  task automatic test_member_saturation();
    int x, y;
    set_idle(0, 52);
    write_regs('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1024, 16'hFFFF, 16'd0});
    for (int i = 0; i < 1030; i++) begin
      x = $urandom_range(65535);
      y = $urandom_range(65535);
      push_point(mk_pt(x, y, x ^ 1, y, 1, int'(i == 1029)));
    end
  endtask

  task automatic test_random_traffic();
    reg_words_t w;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idle(0, 0);
        1: set_idle(52, 0);
        2: set_idle(0, 52);
        default: set_idle(19, 19);
      endcase
      if (ph == 0) w = DEFAULT_REGS;
      else random_regs(w);
      write_regs(w);
      random_frames(60);
    end
  endtask

  initial begin
    err_cnt     = 0;
    points_sent = 0;
    set_idle(0, 0);
    for (int i = 0; i < 8; i++) store_reg(cfg_idx_e'(i), DEFAULT_REGS[i]);
    clear_frame();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_frames();
    test_motion_limits();
    test_seed_outside_window();
    test_good_box();
    test_box_overflow();
    test_field_extremes();
    test_config_sweep();
    test_member_saturation();
    test_random_traffic();
    wait_drained();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tpbc_pkg.sv
rtl/tpbc_front.sv
rtl/tpbc_fifo.sv
rtl/tpbc_back.sv
rtl/tpbc_result.sv
rtl/tracked_point_box_clusterer_unit.sv
verif/tb.sv
